// File: rtl/ght_pkg.sv
// Shared constants, request/result words and codes for the generational handle table.
package ght_pkg;

    localparam int SLOTS     = 256;
    localparam int GEN_BITS  = 16;
    localparam int REF_BITS  = 32;
    localparam int KIND_BITS = 3;
    localparam int IDX_BITS  = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_LOOKUP     = 2'd2,
        REQ_NONE       = 2'd3
    } t_req_e;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOT_REG  = 3'd4,
        ST_NULL     = 3'd5
    } t_status_e;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [REF_BITS-1:0]  object_ref;
        logic [KIND_BITS-1:0] object_kind;
        logic [IDX_BITS-1:0]  slot_index;
        logic [GEN_BITS-1:0]  handle_gen;
    } t_in_word;

    typedef struct packed {
        logic [2:0]           status;
        logic [IDX_BITS-1:0]  out_index;
        logic [GEN_BITS-1:0]  out_gen;
        logic [REF_BITS-1:0]  found_ref;
        logic                 handle_valid;
        logic [CNT_BITS-1:0]  live_count;
        logic [CNT_BITS-1:0]  retired_count;
        logic [CNT_BITS-1:0]  free_count;
    } t_out_word;

    typedef struct packed {
        logic [GEN_BITS-1:0]  gen;
        logic [REF_BITS-1:0]  obj_ref;
        logic [KIND_BITS-1:0] kind;
    } t_slot_entry;

    typedef struct packed {
        logic                 slot_we;
        t_slot_entry          slot_wdata;
        logic                 stk_we;
        logic [IDX_BITS-1:0]  stk_waddr;
        logic [IDX_BITS-1:0]  stk_wdata;
        logic                 pop;
        logic [CNT_BITS-1:0]  depth;
        logic [CNT_BITS-1:0]  live;
        logic [CNT_BITS-1:0]  retired;
    } t_update;

endpackage

// File: rtl/ght_ram.sv
// Generic single-port-write, registered-read RAM.
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/ght_exec.sv
// Decision and update unit: checks one request against its slot entry and counters.
module ght_exec (
    input  ght_pkg::t_in_word                     i_req,
    input  ght_pkg::t_slot_entry                  i_entry,
    input  logic [ght_pkg::IDX_BITS-1:0]          i_slot,
    input  logic [ght_pkg::CNT_BITS-1:0]          i_depth,
    input  logic [ght_pkg::CNT_BITS-1:0]          i_live,
    input  logic [ght_pkg::CNT_BITS-1:0]          i_retired,
    output ght_pkg::t_out_word                    o_out,
    output ght_pkg::t_update                      o_upd
);

    localparam logic [ght_pkg::GEN_BITS-1:0] GEN_MAX = '1;

    logic [ght_pkg::GEN_BITS-1:0] gen_inc;
    logic                         idx_ok;
    logic                         gen_hit;

    assign gen_inc = ght_pkg::GEN_BITS'(i_entry.gen + 1'b1);
    assign idx_ok  = (32'(i_req.slot_index) < ght_pkg::SLOTS);
    assign gen_hit = idx_ok && (i_entry.gen == i_req.handle_gen);

    always_comb begin
        o_upd         = '0;
        o_upd.depth   = i_depth;
        o_upd.live    = i_live;
        o_upd.retired = i_retired;
        o_out         = '0;
        o_out.status  = ght_pkg::ST_OK;

        unique case (i_req.req_type)
            ght_pkg::REQ_REGISTER: begin
                priority if (i_req.object_ref == '0) begin
                    o_out.status = ght_pkg::ST_NULL;
                end else if (i_depth == '0) begin
                    o_out.status = ght_pkg::ST_FULL;
                end else begin
                    o_upd.pop                = 1'b1;
                    o_upd.depth              = ght_pkg::CNT_BITS'(i_depth - 1'b1);
                    o_upd.live               = ght_pkg::CNT_BITS'(i_live + 1'b1);
                    o_upd.slot_we            = 1'b1;
                    o_upd.slot_wdata.gen     = gen_inc;
                    o_upd.slot_wdata.obj_ref = i_req.object_ref;
                    o_upd.slot_wdata.kind    = i_req.object_kind;
                    o_out.out_index          = i_slot;
                    o_out.out_gen            = gen_inc;
                end
            end
            ght_pkg::REQ_UNREGISTER, ght_pkg::REQ_LOOKUP: begin
                priority if (i_req.handle_gen == '0) begin
                    o_out.status = ght_pkg::ST_EMPTY;
                end else if (!gen_hit) begin
                    o_out.status = ght_pkg::ST_MISMATCH;
                end else if (i_entry.obj_ref == '0) begin
                    o_out.status = ght_pkg::ST_NOT_REG;
                end else if (i_req.req_type == ght_pkg::REQ_UNREGISTER) begin
                    // The generation stays so that stale handles keep missing.
                    o_upd.slot_we        = 1'b1;
                    o_upd.slot_wdata.gen = i_entry.gen;
                    if (i_entry.gen != GEN_MAX) begin
                        if (32'(i_depth) < ght_pkg::SLOTS) begin
                            o_upd.stk_we    = 1'b1;
                            o_upd.stk_waddr = ght_pkg::IDX_BITS'(i_depth);
                            o_upd.stk_wdata = i_slot;
                            o_upd.depth     = ght_pkg::CNT_BITS'(i_depth + 1'b1);
                        end
                    end else begin
                        o_upd.retired = ght_pkg::CNT_BITS'(i_retired + 1'b1);
                    end
                    if (i_live != '0) begin
                        o_upd.live = ght_pkg::CNT_BITS'(i_live - 1'b1);
                    end
                end else begin
                    o_out.found_ref    = i_entry.obj_ref;
                    o_out.handle_valid = 1'b1;
                end
            end
            default: begin
                o_out.status = ght_pkg::ST_OK;
            end
        endcase

        o_out.live_count    = o_upd.live;
        o_out.retired_count = o_upd.retired;
        o_out.free_count    = o_upd.depth;
    end

endmodule

// File: rtl/generational_handle_table_top.sv
// Top level of the generational handle table: sequencer, memories and counters.
//
// Requests enter on the input channel (i_in_valid, o_in_stall, i_in_data) and
// every request gives exactly one result word on the output channel
// (o_out_valid, i_out_stall, o_out_data).
// An accepted request then passes through S_SLOT, where the free-stack read
// result picks the slot, and S_EXEC, where the slot read result is checked
// and written back. The result is registered with that write-back. The block
// takes no new request until the last one has been written back.
// While a result waits under i_out_stall, the next request is still taken and
// carried up to its write-back, where it holds until the output register frees.
// Reset clears the sequencer, the counters, a valid bit per slot (an invalid
// slot reads as generation zero and a null reference) and a low-water mark
// of the free stack. Stack entries never popped read as their reset index, so
// no clearing pass runs and requests are taken right after reset.
module generational_handle_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ght_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ght_pkg::t_out_word o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SLOT,
        S_EXEC
    } t_state_e;

    t_state_e                      r_state, n_state;
    ght_pkg::t_in_word             r_req, n_req;
    logic [ght_pkg::IDX_BITS-1:0]  r_slot, n_slot;
    logic                          r_entry_vld, n_entry_vld;
    logic [ght_pkg::SLOTS-1:0]     r_slot_vld, n_slot_vld;
    logic [ght_pkg::CNT_BITS-1:0]  r_depth, n_depth;
    logic [ght_pkg::CNT_BITS-1:0]  r_low, n_low;
    logic [ght_pkg::CNT_BITS-1:0]  r_live, n_live;
    logic [ght_pkg::CNT_BITS-1:0]  r_retired, n_retired;
    logic                          r_out_valid, n_out_valid;
    ght_pkg::t_out_word            r_out, n_out;

    logic [ght_pkg::IDX_BITS-1:0]  stk_raddr;
    logic [ght_pkg::IDX_BITS-1:0]  stk_rdata;
    logic [ght_pkg::IDX_BITS-1:0]  popped;
    logic [ght_pkg::IDX_BITS-1:0]  slot_raddr;
    ght_pkg::t_slot_entry          slot_rdata;
    ght_pkg::t_slot_entry          entry;
    ght_pkg::t_out_word            exec_out;
    ght_pkg::t_update              upd;
    logic                          commit;

    assign stk_raddr = ght_pkg::IDX_BITS'(r_depth - 1'b1);

    // At the low-water mark the top entry has never been written since reset.
    assign popped = (r_low == r_depth) ?
                    ght_pkg::IDX_BITS'(ght_pkg::SLOTS - 32'(r_depth)) : stk_rdata;

    assign n_slot = (r_state == S_SLOT) ?
                    ((r_req.req_type == ght_pkg::REQ_REGISTER) ? popped : r_req.slot_index) :
                    r_slot;
    assign slot_raddr = n_slot;

    assign entry  = r_entry_vld ? slot_rdata : '0;
    assign commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    ght_ram #(
        .WIDTH (ght_pkg::IDX_BITS),
        .DEPTH (ght_pkg::SLOTS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (commit && upd.stk_we),
        .i_waddr (upd.stk_waddr),
        .i_wdata (upd.stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    ght_ram #(
        .WIDTH ($bits(ght_pkg::t_slot_entry)),
        .DEPTH (ght_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (commit && upd.slot_we),
        .i_waddr (r_slot),
        .i_wdata (upd.slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    ght_exec u_exec (
        .i_req     (r_req),
        .i_entry   (entry),
        .i_slot    (r_slot),
        .i_depth   (r_depth),
        .i_live    (r_live),
        .i_retired (r_retired),
        .o_out     (exec_out),
        .o_upd     (upd)
    );

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_entry_vld = r_entry_vld;
        n_slot_vld  = r_slot_vld;
        n_depth     = r_depth;
        n_low       = r_low;
        n_live      = r_live;
        n_retired   = r_retired;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req   = i_in_data;
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                n_entry_vld = r_slot_vld[n_slot];
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                if (commit) begin
                    if (upd.slot_we) begin
                        n_slot_vld[r_slot] = 1'b1;
                    end
                    if (upd.pop && (upd.depth < r_low)) begin
                        n_low = upd.depth;
                    end
                    n_depth     = upd.depth;
                    n_live      = upd.live;
                    n_retired   = upd.retired;
                    n_out       = exec_out;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot_vld  <= '0;
            r_depth     <= ght_pkg::CNT_BITS'(ght_pkg::SLOTS);
            r_low       <= ght_pkg::CNT_BITS'(ght_pkg::SLOTS);
            r_live      <= '0;
            r_retired   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot_vld  <= n_slot_vld;
            r_depth     <= n_depth;
            r_low       <= n_low;
            r_live      <= n_live;
            r_retired   <= n_retired;
            r_out_valid <= n_out_valid;
        end
        r_req       <= n_req;
        r_slot      <= n_slot;
        r_entry_vld <= n_entry_vld;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Every slot is either free, live or retired.
    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_depth) + 32'(r_live) + 32'(r_retired)) == ght_pkg::SLOTS)
        else $error("free, live and retired counts do not add up to the slot count");

    // The stack never sits below its recorded low-water mark.
    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_depth)
        else $error("free stack depth below its low-water mark");

    // A new result word is loaded only by a write-back cycle.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result word appeared without a write-back");

endmodule
